// File: src/tdg_pkg.sv
package tdg_pkg;

    // Field widths
    localparam int DIST_BITS    = 16;
    localparam int FRAC_BITS    = 12;
    localparam int INV_RES_BITS = 16;
    localparam int GRAD_BITS    = 32;

    // A difference of two distances needs one more bit
    localparam int DIFF_BITS    = DIST_BITS + 1;

    localparam logic [INV_RES_BITS-1:0] INV_RES_RESET = INV_RES_BITS'(853);

    typedef struct packed {
        logic        [FRAC_BITS-1:0] frac_x;
        logic        [FRAC_BITS-1:0] frac_y;
        logic        [FRAC_BITS-1:0] frac_z;
        logic signed [DIST_BITS-1:0] dist_000;
        logic signed [DIST_BITS-1:0] dist_001;
        logic signed [DIST_BITS-1:0] dist_010;
        logic signed [DIST_BITS-1:0] dist_011;
        logic signed [DIST_BITS-1:0] dist_100;
        logic signed [DIST_BITS-1:0] dist_101;
        logic signed [DIST_BITS-1:0] dist_110;
        logic signed [DIST_BITS-1:0] dist_111;
    } t_in_item;

    typedef struct packed {
        logic signed [DIST_BITS-1:0] distance;
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic signed [GRAD_BITS-1:0] grad_z;
    } t_out_item;

endpackage

// File: src/tdg_lerp_lane.sv
module tdg_lerp_lane #(
    parameter int WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [WIDTH-1:0]       i_a,
    input  logic signed [WIDTH-1:0]       i_b,
    input  logic [tdg_pkg::FRAC_BITS-1:0] i_f,
    output logic signed [WIDTH-1:0]       o_y
);
    import tdg_pkg::*;

    localparam int PW = WIDTH + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));

    logic signed [WIDTH:0]   diff;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_rnd;
    logic signed [PW-1:0]    step;
    logic [WIDTH:0]          sum;
    logic signed [WIDTH-1:0] r_y;

    // Blend as a + round((b - a) * f), round half up; the blend is convex
    // so the sum always fits back into WIDTH bits
    always_comb begin
        diff     = {i_b[WIDTH-1], i_b} - {i_a[WIDTH-1], i_a};
        prod     = diff * $signed({1'b0, i_f});
        prod_rnd = prod + HALF;
        step     = prod_rnd >>> FRAC_BITS;
        sum      = {i_a[WIDTH-1], i_a} + step[WIDTH:0];
    end

    // Hold the lane result until the stage advances
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= sum[WIDTH-1:0];
        end
    end

    assign o_y = r_y;

endmodule

// File: src/tdg_grad_scale.sv
module tdg_grad_scale (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [tdg_pkg::INV_RES_BITS-1:0]     i_inv_res,
    input  logic signed [tdg_pkg::DIST_BITS-1:0] i_dist,
    input  logic signed [tdg_pkg::DIFF_BITS-1:0] i_gx,
    input  logic signed [tdg_pkg::DIFF_BITS-1:0] i_gy,
    input  logic signed [tdg_pkg::DIFF_BITS-1:0] i_gz,
    output tdg_pkg::t_out_item                   o_item
);
    import tdg_pkg::*;

    localparam int PW = DIFF_BITS + INV_RES_BITS + 1;
    localparam logic signed [PW-1:0] GMAX = PW'((64'sd1 <<< (GRAD_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] GMIN = -GMAX - PW'(1);

    logic signed [INV_RES_BITS:0] scale;
    logic signed [PW-1:0]         px;
    logic signed [PW-1:0]         py;
    logic signed [PW-1:0]         pz;
    t_out_item                    n_item;
    t_out_item                    r_item;

    function automatic logic [GRAD_BITS-1:0] sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] c;
        begin
            c = p;
            if (p > GMAX) begin
                c = GMAX;
            end else if (p < GMIN) begin
                c = GMIN;
            end
            return c[GRAD_BITS-1:0];
        end
    endfunction

    // Scale each blended difference by the reciprocal voxel size and clamp
    always_comb begin
        scale           = $signed({1'b0, i_inv_res});
        px              = i_gx * scale;
        py              = i_gy * scale;
        pz              = i_gz * scale;
        n_item.distance = i_dist;
        n_item.grad_x   = sat(px);
        n_item.grad_y   = sat(py);
        n_item.grad_z   = sat(pz);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: src/trilinear_distance_gradient_unit.sv
// Trilinear distance interpolation with gradient. Each item carries the
// eight corner distances of one voxel cell (Q8.8) and the query offsets in
// the cell (Q0.12); the result is the interpolated distance and its x, y, z
// gradient scaled by inv_resolution (Q8.8) into saturated Q16.16. The unit
// takes one item per clock unless every stage is full and the output
// stalls, and presents its result on the output through four register
// stages: three blend stages of parallel lerp lanes (along x, then y, then
// z) and one scaling stage with three multipliers feeding the output
// register. A stall at the output holds the pipeline only once every stage
// is full; bubbles are squeezed out. inv_resolution resets to 853 and is
// written through the configuration channel, which is always ready; write
// it only while no item is in flight.
module trilinear_distance_gradient_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  tdg_pkg::t_in_item                       i_in_item,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output tdg_pkg::t_out_item                      o_out_item,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [tdg_pkg::INV_RES_BITS-1:0]        i_cfg_data
);
    import tdg_pkg::*;

    // Stage control
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic en1, en2, en3, en4;

    logic [INV_RES_BITS-1:0] r_inv_res;

    // Stage 1 payload
    logic signed [DIST_BITS-1:0] vx00, vx01, vx10, vx11;
    logic signed [DIFF_BITS-1:0] r1_dx00, r1_dx01, r1_dx10, r1_dx11;
    logic [FRAC_BITS-1:0]        r1_fy, r1_fz;

    // Stage 2 payload
    logic signed [DIST_BITS-1:0] vy0, vy1;
    logic signed [DIFF_BITS-1:0] gxp0, gxp1;
    logic signed [DIFF_BITS-1:0] r2_gyd0, r2_gyd1;
    logic [FRAC_BITS-1:0]        r2_fz;

    // Stage 3 payload
    logic signed [DIST_BITS-1:0] dist3;
    logic signed [DIFF_BITS-1:0] gx3, gy3;
    logic signed [DIFF_BITS-1:0] r3_gz;

    function automatic logic signed [DIFF_BITS-1:0] sub_ext(
        input logic signed [DIST_BITS-1:0] hi,
        input logic signed [DIST_BITS-1:0] lo
    );
        return {hi[DIST_BITS-1], hi} - {lo[DIST_BITS-1], lo};
    endfunction

    // Ready chain: a stage loads when empty or when its successor moves
    always_comb begin
        rdy4 = !r_v4 || !i_out_stall;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        en1  = rdy1 && i_in_valid;
        en2  = rdy2 && r_v1;
        en3  = rdy3 && r_v2;
        en4  = rdy4 && r_v3;
    end

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_v4;
    assign o_cfg_ready = 1'b1;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_res <= INV_RES_RESET;
        end else if (i_cfg_valid) begin
            r_inv_res <= i_cfg_data;
        end
    end

    // Stage 1: blend along x, take corner differences along x
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_lx00 (
        .i_clk(i_clk), .i_en(en1), .i_a(i_in_item.dist_000), .i_b(i_in_item.dist_100),
        .i_f(i_in_item.frac_x), .o_y(vx00));
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_lx01 (
        .i_clk(i_clk), .i_en(en1), .i_a(i_in_item.dist_001), .i_b(i_in_item.dist_101),
        .i_f(i_in_item.frac_x), .o_y(vx01));
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_lx10 (
        .i_clk(i_clk), .i_en(en1), .i_a(i_in_item.dist_010), .i_b(i_in_item.dist_110),
        .i_f(i_in_item.frac_x), .o_y(vx10));
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_lx11 (
        .i_clk(i_clk), .i_en(en1), .i_a(i_in_item.dist_011), .i_b(i_in_item.dist_111),
        .i_f(i_in_item.frac_x), .o_y(vx11));

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_dx00 <= sub_ext(i_in_item.dist_100, i_in_item.dist_000);
            r1_dx01 <= sub_ext(i_in_item.dist_101, i_in_item.dist_001);
            r1_dx10 <= sub_ext(i_in_item.dist_110, i_in_item.dist_010);
            r1_dx11 <= sub_ext(i_in_item.dist_111, i_in_item.dist_011);
            r1_fy   <= i_in_item.frac_y;
            r1_fz   <= i_in_item.frac_z;
        end
    end

    // Stage 2: blend along y, blend the x differences for the x gradient, take differences along y
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_ly0 (
        .i_clk(i_clk), .i_en(en2), .i_a(vx00), .i_b(vx10), .i_f(r1_fy), .o_y(vy0));
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_ly1 (
        .i_clk(i_clk), .i_en(en2), .i_a(vx01), .i_b(vx11), .i_f(r1_fy), .o_y(vy1));
    tdg_lerp_lane #(.WIDTH(DIFF_BITS)) u_lgx0 (
        .i_clk(i_clk), .i_en(en2), .i_a(r1_dx00), .i_b(r1_dx10), .i_f(r1_fy), .o_y(gxp0));
    tdg_lerp_lane #(.WIDTH(DIFF_BITS)) u_lgx1 (
        .i_clk(i_clk), .i_en(en2), .i_a(r1_dx01), .i_b(r1_dx11), .i_f(r1_fy), .o_y(gxp1));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_gyd0 <= sub_ext(vx10, vx00);
            r2_gyd1 <= sub_ext(vx11, vx01);
            r2_fz   <= r1_fz;
        end
    end

    // Stage 3: blend along z, take the difference along z
    tdg_lerp_lane #(.WIDTH(DIST_BITS)) u_lz (
        .i_clk(i_clk), .i_en(en3), .i_a(vy0), .i_b(vy1), .i_f(r2_fz), .o_y(dist3));
    tdg_lerp_lane #(.WIDTH(DIFF_BITS)) u_lgy (
        .i_clk(i_clk), .i_en(en3), .i_a(r2_gyd0), .i_b(r2_gyd1), .i_f(r2_fz), .o_y(gy3));
    tdg_lerp_lane #(.WIDTH(DIFF_BITS)) u_lgx (
        .i_clk(i_clk), .i_en(en3), .i_a(gxp0), .i_b(gxp1), .i_f(r2_fz), .o_y(gx3));

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_gz <= sub_ext(vy1, vy0);
        end
    end

    // Stage 4: scale and saturate the gradients into the output register
    tdg_grad_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (en4),
        .i_inv_res(r_inv_res),
        .i_dist   (dist3),
        .i_gx     (gx3),
        .i_gy     (gy3),
        .i_gz     (r3_gz),
        .o_item   (o_out_item)
    );

    // Input stalls only when every stage holds an item and the output waits
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall))
        else $error("input stalled with a free stage");

    // An item leaving stage 3 lands in the output register
    a_stage4_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en4 |=> o_out_valid)
        else $error("item lost between stage 3 and output");

    // Reset restores the default reciprocal
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_inv_res == INV_RES_RESET))
        else $error("inv_resolution not at reset value");

    // A configuration write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_inv_res == $past(i_cfg_data)))
        else $error("configuration write not taken");

endmodule
